@@ rtl/core/rdc_pkg.sv @@
// Package for the radix digit converter: widths, states and the reciprocal table.
package rdc_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;
    localparam int RADIX_W = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } rdc_state_t;

    // ceil(2^32 / r). The quotient taken from the upper half of the product
    // is exact or one too large, and the remainder step corrects it.
    function automatic logic [VALUE_W-1:0] recip(input logic [RADIX_W-1:0] r);
        logic [VALUE_W-1:0] m;
        unique case (r)
            4'd2:    m = 32'd2147483648;
            4'd3:    m = 32'd1431655766;
            4'd4:    m = 32'd1073741824;
            4'd5:    m = 32'd858993460;
            4'd6:    m = 32'd715827883;
            4'd7:    m = 32'd613566757;
            4'd8:    m = 32'd536870912;
            4'd9:    m = 32'd477218589;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/rdc_value_if.sv @@
// Valid/ready channel that carries one unsigned value to be converted.
interface rdc_value_if;
    import rdc_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/core/rdc_digit_if.sv @@
// Valid/ready channel that carries one digit and its last mark.
interface rdc_digit_if;
    import rdc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;

    modport source (output valid, output digit, output last, input ready);
    modport sink   (input valid, input digit, input last, output ready);
endinterface

@@ rtl/core/radix_digit_converter_core.sv @@
// Radix digit converter: integer to base 2..9 digits, most significant first.
//
//   channel   | dir | payload             | handshake
//   ----------+-----+---------------------+-------------------
//   values    | in  | value[31:0]         | valid / ready
//   digits    | out | digit[3:0], last    | valid / ready
//   cfg       | in  | cfg_data[3:0]       | cfg_we, no wait
//
// A word is taken in ST_IDLE; for each digit, ST_MUL runs the shared reciprocal
// multiplier and ST_DIV the remainder step, then ST_EMIT pops one digit per handshake
// on digits. values.ready is high only when idle.
// Reset sets the radix to 2 and empties the stack. A stall on digits holds
// the top of the stack on the output until it is taken.
module radix_digit_converter_core #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
    rdc_value_if.sink              values,
    rdc_digit_if.source            digits
);
    import rdc_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);

    rdc_state_t         state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [VALUE_W-1:0] num_reg, num_next;
    logic [VALUE_W-1:0] qest_reg, qest_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DIGIT_W-1:0] stack_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0] stack_next [MAX_DIGITS];

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W+3:0]   qr;
    logic [VALUE_W+3:0]   diff;
    logic                 over;
    logic [VALUE_W-1:0]   quot;
    logic [DIGIT_W-1:0]   rem;
    logic                 push;
    logic                 pop;

    // Radix register, saturated into 2..9 on write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_data < RADIX_MIN)
            begin
                radix_reg <= RADIX_MIN;
            end
            else if (cfg_data > RADIX_MAX)
            begin
                radix_reg <= RADIX_MAX;
            end
            else
            begin
                radix_reg <= cfg_data;
            end
        end
    end

    assign prod = {{VALUE_W{1'b0}}, num_reg} * {{VALUE_W{1'b0}}, recip(radix_reg)};
    assign qr   = (VALUE_W+4)'(qest_reg) * (VALUE_W+4)'(radix_reg);
    assign diff = (VALUE_W+4)'(num_reg) - qr;
    // A negative difference means the estimated quotient was one too large.
    assign over = diff[VALUE_W+3];
    assign quot = over ? (qest_reg - VALUE_W'(1)) : qest_reg;
    assign rem  = over ? (diff[DIGIT_W-1:0] + DIGIT_W'(radix_reg)) : diff[DIGIT_W-1:0];

    assign push = (state_reg == ST_DIV);
    assign pop  = (state_reg == ST_EMIT) && digits.ready;

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        qest_next  = qest_reg;
        depth_next = depth_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (values.valid)
                begin
                    num_next   = values.value;
                    depth_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                qest_next  = prod[2*VALUE_W-1:VALUE_W];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                num_next   = quot;
                depth_next = depth_reg + DEPTH_W'(1);
                // A zero input still pushes its single 0 digit here.
                if ((quot == '0) || (depth_next == DEPTH_W'(MAX_DIGITS)))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (digits.ready)
                begin
                    depth_next = depth_reg - DEPTH_W'(1);
                    if (depth_reg == DEPTH_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The stack is a shift line: a push enters at the top, a pop shifts back.
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            stack_next[i] = stack_reg[i];
        end
        if (push)
        begin
            stack_next[0] = rem;
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                stack_next[i] = stack_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_DIGITS - 1; i++)
            begin
                stack_next[i] = stack_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        qest_reg <= qest_next;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            stack_reg[i] <= stack_next[i];
        end
    end

    assign values.ready = (state_reg == ST_IDLE);
    assign digits.valid = (state_reg == ST_EMIT);
    assign digits.digit = stack_reg[0];
    assign digits.last  = (depth_reg == DEPTH_W'(1));

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        digits.valid |-> (depth_reg != '0))
        else $error("digit shown with an empty stack");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digits.valid |-> (digits.digit < radix_reg))
        else $error("digit not below the radix");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (rem < radix_reg))
        else $error("remainder step left a remainder not below the radix");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (values.valid && values.ready) |=> (state_reg == ST_MUL) && (depth_reg == '0))
        else $error("accepted word did not start a conversion");

    a_pop_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (digits.valid && digits.ready && !digits.last) |=> digits.valid)
        else $error("digits stopped before the last mark");

endmodule
